// File: design/ssi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared widths, register indexes, weight codes and control types for the
// streaming Simpson integrator.
// ----------------------------------------------------------------------------
package ssi_pkg;

    localparam int NUM_POINTS_W    = 17;
    localparam int STEP_W          = 32;
    localparam int CFG_DATA_W      = 32;
    localparam int CFG_INDEX_W     = 2;
    localparam int RESULT_W        = 64;

    localparam int DEF_MAX_POINTS  = 65536;
    localparam int DEF_SAMPLE_BITS = 24;

    localparam int NUM_POINTS_RESET = 3;
    localparam int MIN_POINTS       = 3;
    localparam logic [STEP_W-1:0] STEP_RESET = 32'h0100_0000;

    localparam logic [CFG_INDEX_W-1:0] REG_NUM_POINTS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_SIZE  = 2'd1;

    // finishing pipeline: 3 divide stages plus 7 others
    localparam int DIV_STAGES = 3;
    localparam int NUM_STAGES = DIV_STAGES + 7;

    localparam logic signed [RESULT_W-1:0] RESULT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [RESULT_W-1:0] RESULT_MIN = 64'h8000_0000_0000_0000;

    typedef enum logic [1:0] {
        WS_ZERO,
        WS_ONE,
        WS_TWO,
        WS_FOUR
    } ws_t;

    typedef enum logic [1:0] {
        WT_ZERO,
        WT_ONE,
        WT_THREE
    } wt_t;

    typedef struct packed {
        logic acc;
        logic last;
        logic clear;
        logic err;
        ws_t  ws;
        wt_t  wt;
    } acc_ctl_t;

endpackage
`default_nettype wire

// File: design/ssi_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssi_lane
// One component of the integrator: weighted accumulation of samples and the
// pipelined finish (8S + 9T) * h / 24 with truncation and saturation.
// ----------------------------------------------------------------------------
module ssi_lane
    import ssi_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int SUM_W       = 43,
    parameter int END_W       = 28,
    parameter int P_W         = 47
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire acc_ctl_t                      ctl,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic [STEP_W-1:0]             step_size,
    input  wire logic [NUM_STAGES-1:0]         adv,
    output logic signed [RESULT_W-1:0]         result
);

    localparam int A_W       = (P_W > STEP_W) ? P_W : STEP_W + 1;
    localparam int HI_W      = A_W - STEP_W;
    localparam int P1_W      = HI_W + STEP_W;
    localparam int PROD_W    = A_W + STEP_W;
    localparam int X_W       = PROD_W - 3;
    localparam int SAT_W     = (X_W > 65) ? X_W : 65;
    localparam int DIGITS    = 3;
    localparam int DIV_W     = DIV_STAGES * DIGITS * 8;
    localparam int DIV_FIRST = 5;
    localparam int DIV_LAST  = NUM_STAGES - 2;
    localparam int OUT_STAGE = NUM_STAGES - 1;
    localparam logic [SAT_W-1:0] SAT_LIM = SAT_W'({2'b11, 63'd0});
    localparam logic [9:0] DIV3_RECIP = 10'd683;

    typedef struct packed {
        logic [DIV_W-1:0] w;
        logic [DIV_W-1:0] q;
        logic [1:0]       r;
    } div_t;

    function automatic div_t div3_bytes(input div_t d);
        div_t        o;
        logic [9:0]  v;
        logic [19:0] prod;
        logic [7:0]  qd;
        logic [9:0]  rem;
        o = d;
        for (int j = 0; j < DIGITS; j++) begin
            v    = {o.r, o.w[DIV_W-1 -: 8]};
            prod = 20'(v) * 20'(DIV3_RECIP);
            qd   = prod[18:11];
            rem  = v - 10'({qd, 1'b0}) - 10'(qd);
            o.r  = rem[1:0];
            o.w  = o.w << 8;
            o.q  = {o.q[DIV_W-9:0], qd};
        end
        return o;
    endfunction

    logic signed [SUM_W-1:0]  sum_acc_reg;
    logic signed [END_W-1:0]  end_acc_reg;
    logic signed [SUM_W-1:0]  ws_term;
    logic signed [END_W-1:0]  wt_term;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [END_W-1:0]  end_next;

    logic signed [SUM_W-1:0]  sum_s0_reg;
    logic signed [END_W-1:0]  end_s0_reg;
    logic signed [P_W-1:0]    p_reg;
    logic signed [P_W-1:0]    p_next;
    logic [P_W-1:0]           p_mag;
    logic [A_W-1:0]           a_reg;
    logic [2*STEP_W-1:0]      p0_reg;
    logic [P1_W-1:0]          p1_reg;
    logic [PROD_W-1:0]        prod;
    logic [X_W-1:0]           x_reg;
    logic [SAT_W-1:0]         x_wide;
    logic                     neg_reg [2:DIV_LAST];
    logic                     sat_reg [DIV_FIRST:DIV_LAST];
    div_t                     div_reg [DIV_FIRST:DIV_LAST];
    logic [RESULT_W-1:0]      q_fin;
    logic signed [RESULT_W-1:0] result_next;
    logic signed [RESULT_W-1:0] result_reg;

    always_comb begin
        unique case (ctl.ws)
            WS_ZERO: ws_term = '0;
            WS_ONE:  ws_term = SUM_W'(sample);
            WS_TWO:  ws_term = SUM_W'(sample) <<< 1;
            WS_FOUR: ws_term = SUM_W'(sample) <<< 2;
        endcase
        case (ctl.wt)
            WT_ONE:   wt_term = END_W'(sample);
            WT_THREE: wt_term = (END_W'(sample) <<< 1) + END_W'(sample);
            default:  wt_term = '0;
        endcase
        sum_next = sum_acc_reg + ws_term;
        end_next = end_acc_reg + wt_term;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_acc_reg <= '0;
            end_acc_reg <= '0;
        end else if (ctl.clear) begin
            sum_acc_reg <= '0;
            end_acc_reg <= '0;
        end else if (ctl.acc) begin
            sum_acc_reg <= ctl.last ? '0 : sum_next;
            end_acc_reg <= ctl.last ? '0 : end_next;
        end
    end

    always_comb begin
        p_next = (P_W'(sum_s0_reg) <<< 3) + (P_W'(end_s0_reg) <<< 3) + P_W'(end_s0_reg);
        p_mag  = p_reg[P_W-1] ? ($unsigned(~p_reg) + P_W'(1)) : $unsigned(p_reg);
        prod   = PROD_W'(p0_reg) + (PROD_W'(p1_reg) << STEP_W);
        x_wide = SAT_W'(x_reg);
        q_fin  = div_reg[DIV_LAST].q[RESULT_W-1:0];
        if (sat_reg[DIV_LAST]) begin
            result_next = neg_reg[DIV_LAST] ? RESULT_MIN : RESULT_MAX;
        end else if (neg_reg[DIV_LAST]) begin
            result_next = $signed(RESULT_W'(0) - q_fin);
        end else begin
            result_next = $signed(q_fin);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            sum_s0_reg <= ctl.err ? '0 : sum_next;
            end_s0_reg <= ctl.err ? '0 : end_next;
        end
        if (adv[1]) begin
            p_reg <= p_next;
        end
        if (adv[2]) begin
            a_reg      <= A_W'(p_mag);
            neg_reg[2] <= p_reg[P_W-1];
        end
        if (adv[3]) begin
            p0_reg <= (2*STEP_W)'(a_reg[STEP_W-1:0]) * (2*STEP_W)'(step_size);
            p1_reg <= P1_W'(a_reg[A_W-1:STEP_W]) * P1_W'(step_size);
        end
        if (adv[4]) begin
            x_reg <= prod[PROD_W-1:3];
        end
        if (adv[DIV_FIRST]) begin
            sat_reg[DIV_FIRST]   <= x_wide >= SAT_LIM;
            div_reg[DIV_FIRST].w <= DIV_W'(x_wide[64:0]);
            div_reg[DIV_FIRST].q <= '0;
            div_reg[DIV_FIRST].r <= '0;
        end
        for (int k = 3; k <= DIV_LAST; k++) begin
            if (adv[k]) begin
                neg_reg[k] <= neg_reg[k-1];
            end
        end
        for (int k = DIV_FIRST + 1; k <= DIV_LAST; k++) begin
            if (adv[k]) begin
                sat_reg[k] <= sat_reg[k-1];
                div_reg[k] <= div3_bytes(div_reg[k-1]);
            end
        end
        if (adv[OUT_STAGE]) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule
`default_nettype wire

// File: design/simpson_stream_integrator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// simpson_stream_integrator
// Streaming composite Simpson integrator with a 3/8-rule end for even lengths.
//
// Samples enter on the s_ request channel (valid/ready), one per cycle
// while s_ready is high. Every num_points-th sample closes an integral; its
// result leaves on the m_ request channel through a 10-stage finishing
// pipeline (accumulate, weight sum, magnitude, split 32-bit multiply, add,
// range check, three divide-by-three stages, output register). Sustained
// rate is one sample per cycle while the receiver takes results. Other
// samples only update the running sums. With num_points below 3 every
// sample yields a result with m_error set and zero integrals.
// When the receiver stalls, results queue in the pipeline stages; s_ready
// drops only once every stage holds a result. Configuration is written on
// cfg_wr_en; a num_points write restarts the integral. Reset clears the
// sums, the sample count and the pipeline, and loads num_points = 3 and
// step_size = 1.0.
// ----------------------------------------------------------------------------
module simpson_stream_integrator
    import ssi_pkg::*;
#(
    parameter int MAX_POINTS  = DEF_MAX_POINTS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0]        cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         cfg_wr_data,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] s_sample_re,
    input  wire logic signed [SAMPLE_BITS-1:0] s_sample_im,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [RESULT_W-1:0]         m_integral_re,
    output logic signed [RESULT_W-1:0]         m_integral_im,
    output logic                               m_error
);

    localparam int IDX_W = $clog2(MAX_POINTS + 1);
    localparam int CMP_W = (IDX_W > NUM_POINTS_W) ? IDX_W : NUM_POINTS_W;
    localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_POINTS) + 3;
    localparam int END_W = SAMPLE_BITS + 4;
    localparam int P_W   = SUM_W + 4;

    logic [IDX_W-1:0]      n_reg;
    logic [IDX_W-1:0]      n_next;
    logic [STEP_W-1:0]     step_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;
    logic [CMP_W-1:0]      np_in;
    logic [CMP_W-1:0]      np_clamp;
    logic                  wr_np;
    logic                  wr_step;

    logic [IDX_W-1:0]      n_m1;
    logic [IDX_W-1:0]      n_m2;
    logic [IDX_W-1:0]      n_m3;
    logic [IDX_W-1:0]      n_m4;
    logic [IDX_W-1:0]      simp_last;
    logic [IDX_W-1:0]      pos;
    logic                  even;
    logic                  is_err;
    logic                  is_last;
    logic                  s_accept;
    ws_t                   ws;
    wt_t                   wt;
    acc_ctl_t              ctl;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] err_reg;
    logic [NUM_STAGES-1:0] err_in;
    logic [NUM_STAGES-1:0] vin;
    logic [NUM_STAGES-1:0] rdy;
    logic [NUM_STAGES-1:0] adv;

    assign wr_np    = cfg_wr_en && (cfg_index == REG_NUM_POINTS);
    assign wr_step  = cfg_wr_en && (cfg_index == REG_STEP_SIZE);
    assign np_in    = CMP_W'(cfg_wr_data[NUM_POINTS_W-1:0]);
    assign np_clamp = (np_in > CMP_W'(MAX_POINTS)) ? CMP_W'(MAX_POINTS) : np_in;
    assign n_next   = np_clamp[IDX_W-1:0];

    always_comb begin
        n_m1      = n_reg - IDX_W'(1);
        n_m2      = n_reg - IDX_W'(2);
        n_m3      = n_reg - IDX_W'(3);
        n_m4      = n_reg - IDX_W'(4);
        even      = !n_reg[0];
        simp_last = even ? n_m4 : n_m1;
        is_err    = n_reg < IDX_W'(MIN_POINTS);
        pos       = (idx_reg >= n_m1) ? n_m1 : idx_reg;
        is_last   = (pos == n_m1);

        ws = WS_ZERO;
        if ((simp_last != '0) && (pos <= simp_last)) begin
            if ((pos == '0) || (pos == simp_last)) begin
                ws = WS_ONE;
            end else if (pos[0]) begin
                ws = WS_FOUR;
            end else begin
                ws = WS_TWO;
            end
        end

        wt = WT_ZERO;
        if (even) begin
            if ((pos == n_m4) || (pos == n_m1)) begin
                wt = WT_ONE;
            end else if ((pos == n_m3) || (pos == n_m2)) begin
                wt = WT_THREE;
            end
        end
    end

    always_comb begin
        rdy[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign s_ready  = rdy[0];
    assign s_accept = s_valid && s_ready;

    always_comb begin
        vin[0]    = s_accept && (is_err || is_last);
        err_in[0] = is_err;
        for (int k = 1; k < NUM_STAGES; k++) begin
            vin[k]    = vld_reg[k-1];
            err_in[k] = err_reg[k-1];
        end
        adv      = rdy & vin;
        vld_next = (rdy & vin) | (~rdy & vld_reg);
    end

    always_comb begin
        if (wr_np || (s_accept && (is_err || is_last))) begin
            idx_next = '0;
        end else if (s_accept) begin
            idx_next = pos + IDX_W'(1);
        end else begin
            idx_next = idx_reg;
        end
    end

    always_comb begin
        ctl.acc   = s_accept && !is_err;
        ctl.last  = is_last;
        ctl.clear = wr_np || (s_accept && is_err);
        ctl.err   = is_err;
        ctl.ws    = ws;
        ctl.wt    = wt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg    <= IDX_W'(NUM_POINTS_RESET);
            step_reg <= STEP_RESET;
            idx_reg  <= '0;
            vld_reg  <= '0;
        end else begin
            if (wr_np) begin
                n_reg <= n_next;
            end
            if (wr_step) begin
                step_reg <= cfg_wr_data[STEP_W-1:0];
            end
            idx_reg <= idx_next;
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (adv[k]) begin
                err_reg[k] <= err_in[k];
            end
        end
    end

    ssi_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W),
        .END_W       (END_W),
        .P_W         (P_W)
    ) u_lane_re (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .sample    (s_sample_re),
        .step_size (step_reg),
        .adv       (adv),
        .result    (m_integral_re)
    );

    ssi_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W),
        .END_W       (END_W),
        .P_W         (P_W)
    ) u_lane_im (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .sample    (s_sample_im),
        .step_size (step_reg),
        .adv       (adv),
        .result    (m_integral_im)
    );

    assign m_valid = vld_reg[NUM_STAGES-1];
    assign m_error = err_reg[NUM_STAGES-1];

endmodule
`default_nettype wire

// File: design/ssi_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssi_checker
// Port-level checks for the streaming Simpson integrator, bound to the top.
// ----------------------------------------------------------------------------
module ssi_checker
    import ssi_pkg::*;
(
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_ready,
    input wire logic                       m_valid,
    input wire logic                       m_ready,
    input wire logic signed [RESULT_W-1:0] m_integral_re,
    input wire logic signed [RESULT_W-1:0] m_integral_im,
    input wire logic                       m_error
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_integral_re)
            && $stable(m_integral_im) && $stable(m_error)))
        else $error("result request changed while stalled");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error) |-> ((m_integral_re == '0) && (m_integral_im == '0)))
        else $error("error result carries nonzero integral");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled while output side is free");

endmodule

bind simpson_stream_integrator ssi_checker u_ssi_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_integral_re (m_integral_re),
    .m_integral_im (m_integral_im),
    .m_error       (m_error)
);
`default_nettype wire
